// ----- src/psa_pkg.sv -----
// Shared constants and types for the particle sphere attractor.
package psa_pkg;

  localparam int unsigned SqSteps  = 34;
  localparam int unsigned DivSteps = 31;
  localparam int unsigned RatioBits = 30;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_RADIUS   = 2'd3;

  // Per-particle data that rides alongside the root and divider pipelines.
  typedef struct packed {
    logic [2:0]        osgn;
    logic [2:0][32:0]  omag;
    logic [2:0][31:0]  vel;
    logic [30:0]       dt;
    logic              outside;
    logic              last;
    logic [30:0]       rad;
  } side_t;

endpackage

// ----- src/particle_sphere_attractor_core.sv -----
// Top level of the particle sphere attractor: config port and velocity pipeline.
//
// Input channel: one particle word per accepted valid/ready handshake
// (position, velocity, time step, last mark). Output channel: one word per
// particle, in order, with the updated velocity, the outside flag and the
// last mark. The APB port holds the centre and radius; write it only while
// no particle is in flight.
// In order from input accept to output valid: 3 stages form the
// offset, squares and distance compare, 34 stages take the square root one
// bit each, 1 stage forms the numerator, 31 stages divide one quotient bit
// each, and 3 stages scale, multiply by the time step and saturate.
// Throughput is one particle per cycle. The whole pipeline moves on a single
// enable; while the output word waits for out_ready_i, every stage holds and
// in_ready_o is low, so nothing is lost or repeated.
// Reset clears all stage valid bits and sets the centre and radius registers to zero.
module particle_sphere_attractor_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [30:0]        time_step_i,
  input  logic               last_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic               outside_sphere_o,
  output logic               last_out_o
);

  logic [31:0] cx_q, cy_q, cz_q;
  logic [30:0] rad_q;
  logic        wr;
  logic        en;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      rad_q <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        psa_pkg::REG_CENTER_X: cx_q  <= pwdata;
        psa_pkg::REG_CENTER_Y: cy_q  <= pwdata;
        psa_pkg::REG_CENTER_Z: cz_q  <= pwdata;
        psa_pkg::REG_RADIUS:   rad_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      psa_pkg::REG_CENTER_X: prdata = cx_q;
      psa_pkg::REG_CENTER_Y: prdata = cy_q;
      psa_pkg::REG_CENTER_Z: prdata = cz_q;
      psa_pkg::REG_RADIUS:   prdata = {1'b0, rad_q};
      default:               prdata = '0;
    endcase
  end

  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 0: centre offset, split into sign and magnitude.
  logic [2:0][31:0] cen, pos;
  psa_pkg::side_t   s0_d, s0_q;
  logic             v0_q;

  always_comb begin
    logic [32:0] off;
    cen = {cz_q, cy_q, cx_q};
    pos = {pos_z_i, pos_y_i, pos_x_i};
    s0_d = '0;
    for (int i = 0; i < 3; i++) begin
      off = {cen[i][31], cen[i]} - {pos[i][31], pos[i]};
      s0_d.osgn[i] = off[32];
      s0_d.omag[i] = off[32] ? 33'(~off + 33'd1) : off;
    end
    s0_d.vel  = {vel_z_i, vel_y_i, vel_x_i};
    s0_d.dt   = time_step_i;
    s0_d.last = last_in_i;
    s0_d.rad  = rad_q;
  end

  // Stage 1: squares of the offsets and of the radius.
  logic [2:0][65:0] sq_q;
  logic [61:0]      rr_q;
  psa_pkg::side_t   s1_q;
  logic             v1_q;

  // Stage 2: squared distance and outside test.
  logic [65:0]      ss_q;
  psa_pkg::side_t   s2_d, s2_q;
  logic             v2_q;

  always_comb begin
    s2_d = s1_q;
    s2_d.outside = (sq_q[0] + sq_q[1] + sq_q[2]) > {4'b0000, rr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= s0_q.omag[i] * s0_q.omag[i];
      end
      rr_q <= s0_q.rad * s0_q.rad;
      s1_q <= s0_q;
      ss_q <= sq_q[0] + sq_q[1] + sq_q[2];
      s2_q <= s2_d;
    end
  end

  logic           sr_valid;
  logic [33:0]    root;
  psa_pkg::side_t sr_side;

  psa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   ({2'b00, ss_q}),
    .side_i  (s2_q),
    .valid_o (sr_valid),
    .root_o  (root),
    .side_o  (sr_side)
  );

  // Numerator of the pull ratio; zero when inside so the divider stays sane.
  logic [33:0]    num_q, den_q;
  psa_pkg::side_t sn_q;
  logic           vn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (en) begin
      vn_q <= sr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= (sr_side.outside && root >= {3'b000, sr_side.rad})
               ? 34'(root - {3'b000, sr_side.rad}) : '0;
      den_q <= root;
      sn_q  <= sr_side;
    end
  end

  logic           dv_valid;
  logic [30:0]    ratio;
  psa_pkg::side_t dv_side;

  psa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vn_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (sn_q),
    .valid_o (dv_valid),
    .quot_o  (ratio),
    .side_o  (dv_side)
  );

  // Scale offsets by the ratio, then by the time step.
  logic [2:0][32:0] acc_q;
  psa_pkg::side_t   sa_q;
  logic             va_q;
  logic [2:0][47:0] dvel_q;
  psa_pkg::side_t   sm_q;
  logic             vm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vm_q <= 1'b0;
    end else if (en) begin
      va_q <= dv_valid;
      vm_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [63:0] pa;
    logic [63:0] pm;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa = dv_side.omag[i] * ratio;
        acc_q[i] <= pa[32+psa_pkg::RatioBits:psa_pkg::RatioBits];
        pm = acc_q[i] * sa_q.dt;
        dvel_q[i] <= pm[63:16];
      end
      sa_q <= dv_side;
      sm_q <= sa_q;
    end
  end

  // Output stage: add and saturate when outside, pass the velocity through when inside, and hold the word until taken.
  logic [2:0][31:0] nv_d, nv_q;
  logic             outside_q, last_q;

  always_comb begin
    logic signed [49:0] sum;
    logic signed [49:0] dvs;
    for (int i = 0; i < 3; i++) begin
      dvs = sm_q.osgn[i] ? -$signed({2'b00, dvel_q[i]}) : $signed({2'b00, dvel_q[i]});
      sum = $signed({{18{sm_q.vel[i][31]}}, sm_q.vel[i]}) + dvs;
      if (!sm_q.outside) begin
        nv_d[i] = sm_q.vel[i];
      end else if (sum[49:31] == '0 || sum[49:31] == '1) begin
        nv_d[i] = sum[31:0];
      end else begin
        nv_d[i] = sum[49] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nv_q      <= nv_d;
      outside_q <= sm_q.outside;
      last_q    <= sm_q.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign new_vel_x_o      = nv_q[0];
  assign new_vel_y_o      = nv_q[1];
  assign new_vel_z_o      = nv_q[2];
  assign outside_sphere_o = outside_q;
  assign last_out_o       = last_q;

endmodule

// ----- src/psa_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module psa_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [67:0]          rad_i,
  input  psa_pkg::side_t       side_i,
  output logic                 valid_o,
  output logic [33:0]          root_o,
  output psa_pkg::side_t       side_o
);

  localparam int unsigned N = psa_pkg::SqSteps;

  logic [N-1:0]              valid_q;
  logic [N-1:0][35:0]        rem_q;
  logic [N-1:0][33:0]        root_q;
  logic [N-1:0][67:0]        rad_q;
  psa_pkg::side_t [N-1:0]    side_q;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [35:0]     rem_in;
    logic [33:0]     root_in;
    logic [67:0]     rad_in;
    psa_pkg::side_t  side_in;
    logic            vin;
    logic [37:0]     rem_sh;
    logic [37:0]     trial;
    logic [35:0]     rem_d;
    logic [33:0]     root_d;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vin     = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
      assign vin     = valid_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, rad_in[67:66]};
      trial  = {2'b00, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = 36'(rem_sh - trial);
        root_d = {root_in[32:0], 1'b1};
      end else begin
        rem_d  = rem_sh[35:0];
        root_d = {root_in[32:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= {rad_in[65:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ----- src/psa_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module psa_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [33:0]          num_i,
  input  logic [33:0]          den_i,
  input  psa_pkg::side_t       side_i,
  output logic                 valid_o,
  output logic [30:0]          quot_o,
  output psa_pkg::side_t       side_o
);

  localparam int unsigned N = psa_pkg::DivSteps;

  logic [N-1:0]              valid_q;
  logic [N-1:0][34:0]        rem_q;
  logic [N-1:0][33:0]        den_q;
  logic [N-1:0][30:0]        quot_q;
  psa_pkg::side_t [N-1:0]    side_q;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [34:0]     rem_in;
    logic [33:0]     den_in;
    logic [30:0]     quot_in;
    psa_pkg::side_t  side_in;
    logic            vin;
    logic [34:0]     rem_sh;
    logic [34:0]     rem_d;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, num_i};
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
      assign vin     = valid_i;
      assign rem_sh  = rem_in;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign side_in = side_q[k-1];
      assign vin     = valid_q[k-1];
      assign rem_sh  = {rem_in[33:0], 1'b0};
    end

    always_comb begin
      ge    = rem_sh >= {1'b0, den_in};
      rem_d = ge ? 35'(rem_sh - {1'b0, den_in}) : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quot_q[k] <= {quot_in[29:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign quot_o  = quot_q[N-1];
  assign side_o  = side_q[N-1];

endmodule
